// ----- hw/rtl/bra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants and types of the bit map run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int MAP_BYTES = 128;
    localparam int MAP_AW    = $clog2(MAP_BYTES);
    localparam int CNT_W     = MAP_AW + 1;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_SEARCH = 3'd1;
    localparam logic [2:0] KIND_SET    = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_WIPE   = 3'd4;

    typedef struct packed {
        logic [MAP_AW-1:0] rd_addr;
        logic              wr_en;
        logic [MAP_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clr_en;
        logic [CNT_W-1:0]  clr_count;
    } t_mem_cmd;

    typedef struct packed {
        logic [LEN_W-1:0] run;
        logic             hit;
        logic [IDX_W-1:0] start;
    } t_scan_res;

endpackage

// ----- hw/rtl/bra_map_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_map_mem
// Occupancy byte memory with one valid flag per byte; invalid bytes read free.
// ----------------------------------------------------------------------------
module bra_map_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bra_pkg::t_mem_cmd i_cmd,
    output logic [7:0]        o_rd_byte
);

    logic [7:0]                    r_mem [bra_pkg::MAP_BYTES];
    logic [bra_pkg::MAP_BYTES-1:0] r_vld;
    logic [7:0]                    r_rd_data;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_cmd.rd_addr];
            if (i_cmd.wr_en) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                for (int i = 0; i < bra_pkg::MAP_BYTES; i++) begin
                    if (bra_pkg::CNT_W'(i) < i_cmd.clr_count) begin
                        r_vld[i] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_rd_byte = r_rd_vld ? r_rd_data : 8'h00;

endmodule

// ----- hw/rtl/bra_run_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_run_scan
// Scan step: runs the free-run counter over one map byte.
// ----------------------------------------------------------------------------
module bra_run_scan (
    input  logic [bra_pkg::LEN_W-1:0]  i_run,
    input  logic [bra_pkg::LEN_W-1:0]  i_len,
    input  logic [7:0]                 i_byte,
    input  logic [bra_pkg::MAP_AW-1:0] i_byte_idx,
    output bra_pkg::t_scan_res         o_res
);

    always_comb begin
        o_res.run   = i_run;
        o_res.hit   = 1'b0;
        o_res.start = '0;
        for (int j = 0; j < 8; j++) begin
            if (!o_res.hit) begin
                if (i_byte[j]) begin
                    o_res.run = '0;
                end else begin
                    o_res.run = o_res.run + 1'b1;
                    if (o_res.run == i_len) begin
                        o_res.hit   = 1'b1;
                        o_res.start = {i_byte_idx, 3'(j)} + 10'd1 - i_len[9:0];
                    end
                end
            end
        end
    end

endmodule

// ----- hw/rtl/bitmap_run_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit allocator over an occupancy bit map with bit access and run search.
// ----------------------------------------------------------------------------
// clear map, errors and rejected searches answer in the cycle after the start;
// read, set, clear pass S_BIT; search scans bytes in use, one map byte per cycle
// through the memory read port and the scan step; a hit ends it early
// busy is high while an item is in work; results strobe for one cycle
// reset: map reads free at once (per-byte valid flags), bytes_in_use is 128
// ----------------------------------------------------------------------------
module bitmap_run_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [9:0]  i_bit_index,
    input  logic [10:0] i_run_length,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic        o_bit_value,
    output logic        o_found,
    output logic [9:0]  o_start_index,
    output logic        o_error
);

    typedef enum logic [1:0] {S_IDLE, S_BIT, S_SCAN} t_state;

    t_state                         r_state;
    logic [7:0]                     r_cfg;
    logic [2:0]                     r_kind;
    logic [bra_pkg::IDX_W-1:0]      r_idx;
    logic [bra_pkg::LEN_W-1:0]      r_len;
    logic [bra_pkg::LEN_W-1:0]      r_run;
    logic [bra_pkg::MAP_AW-1:0]     r_addr;
    logic [bra_pkg::MAP_AW-1:0]     r_eval_idx;

    logic [bra_pkg::CNT_W-1:0]      nbytes;
    logic [bra_pkg::LEN_W-1:0]      total;
    logic                           accept;
    logic [7:0]                     rd_byte;
    logic [7:0]                     mod_byte;
    bra_pkg::t_mem_cmd              mem_cmd;
    bra_pkg::t_scan_res             scan_res;

    assign nbytes = (r_cfg > 8'(bra_pkg::MAP_BYTES)) ? bra_pkg::CNT_W'(bra_pkg::MAP_BYTES)
                                                       : bra_pkg::CNT_W'(r_cfg);
    assign total  = {nbytes, 3'b000};
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        mod_byte = rd_byte;
        mod_byte[r_idx[2:0]] = (r_kind == bra_pkg::KIND_SET);
    end

    always_comb begin
        mem_cmd.rd_addr   = r_addr;
        mem_cmd.wr_en     = 1'b0;
        mem_cmd.wr_addr   = r_idx[9:3];
        mem_cmd.wr_data   = mod_byte;
        mem_cmd.clr_en    = 1'b0;
        mem_cmd.clr_count = nbytes;
        if (r_state == S_IDLE) begin
            mem_cmd.rd_addr = (i_kind == bra_pkg::KIND_SEARCH) ? '0 : i_bit_index[9:3];
            mem_cmd.clr_en  = accept && (i_kind == bra_pkg::KIND_WIPE);
        end
        if (r_state == S_BIT) begin
            mem_cmd.wr_en = (r_kind == bra_pkg::KIND_SET) || (r_kind == bra_pkg::KIND_CLEAR);
        end
    end

    bra_map_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mem_cmd),
        .o_rd_byte (rd_byte)
    );

    bra_run_scan u_scan (
        .i_run      (r_run),
        .i_len      (r_len),
        .i_byte     (rd_byte),
        .i_byte_idx (r_eval_idx),
        .o_res      (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 8'd128;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            o_valid       <= 1'b0;
            o_bit_value   <= 1'b0;
            o_found       <= 1'b0;
            o_start_index <= '0;
            o_error       <= 1'b0;
        end else begin
            o_valid       <= 1'b0;
            o_bit_value   <= 1'b0;
            o_found       <= 1'b0;
            o_start_index <= '0;
            o_error       <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_kind     <= i_kind;
                    r_idx      <= i_bit_index;
                    r_len      <= i_run_length;
                    r_run      <= '0;
                    r_addr     <= bra_pkg::MAP_AW'(1);
                    r_eval_idx <= '0;
                    if (start) begin
                        priority if (i_kind == bra_pkg::KIND_READ || i_kind == bra_pkg::KIND_SET
                                     || i_kind == bra_pkg::KIND_CLEAR) begin
                            if ({1'b0, i_bit_index} >= total) begin
                                o_valid <= 1'b1;
                                o_error <= 1'b1;
                            end else begin
                                r_state <= S_BIT;
                            end
                        end else if (i_kind == bra_pkg::KIND_SEARCH) begin
                            if (i_run_length == '0) begin
                                o_valid <= 1'b1;
                                o_error <= 1'b1;
                            end else if (i_run_length > total) begin
                                o_valid <= 1'b1;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (i_kind == bra_pkg::KIND_WIPE) begin
                            o_valid <= 1'b1;
                        end else begin
                            o_valid <= 1'b1;
                            o_error <= 1'b1;
                        end
                    end
                end
                S_BIT: begin
                    o_valid     <= 1'b1;
                    o_bit_value <= (r_kind == bra_pkg::KIND_READ) && rd_byte[r_idx[2:0]];
                    r_state     <= S_IDLE;
                end
                S_SCAN: begin
                    r_addr     <= r_addr + 1'b1;
                    r_eval_idx <= r_eval_idx + 1'b1;
                    r_run      <= scan_res.run;
                    if (scan_res.hit || ({1'b0, r_eval_idx} + 1'b1 == nbytes)) begin
                        o_valid       <= 1'b1;
                        o_found       <= scan_res.hit;
                        o_start_index <= scan_res.hit ? scan_res.start : '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    a_wipe_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == bra_pkg::KIND_WIPE) |=> (o_valid && !o_error))
        else $error("clear map item did not complete in one cycle");

    a_found_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (!o_error && !o_bit_value))
        else $error("found search carries error or bit value");

endmodule

// ----- tb/bitmap_run_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_tb
// Self-checking bench for the bit map run allocator. A queue-fed driver
// offers read, set, clear, wipe and run-search items in random bursts.
// An in-bench model of the occupancy map predicts every result, and a
// monitor compares each strobed result field by field. The map size
// register is stepped through zero, one byte, full, oversize and random
// values between phases, always while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_tb;

    localparam logic [2:0] KIND_RSVD_LO = 3'd5;
    localparam logic [2:0] KIND_RSVD_HI = 3'd7;
    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 125;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  idx;
        logic [10:0] len;
    } t_req;

    typedef struct packed {
        logic       bit_value;
        logic       found;
        logic [9:0] start_index;
        logic       err;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_kind = '0;
    logic [9:0]  i_bit_index = '0;
    logic [10:0] i_run_length = '0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        o_valid;
    logic        o_bit_value;
    logic        o_found;
    logic [9:0]  o_start_index;
    logic        o_error;

    t_req    request_q[$];
    t_answer answer_q[$];
    t_req    drv_req;
    t_answer got;
    t_answer want;

    logic [7:0] occ_map [bra_pkg::MAP_BYTES];
    logic [7:0] cfg_bytes = 8'd128;

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;

    bitmap_run_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_bit_index   (i_bit_index),
        .i_run_length  (i_run_length),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_bit_value   (o_bit_value),
        .o_found       (o_found),
        .o_start_index (o_start_index),
        .o_error       (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected result of one item, updates the model map
    function automatic t_answer alloc_predict(t_req rq);
        t_answer a;
        int nbytes;
        int total;
        int run;
        a = '0;
        nbytes = (cfg_bytes > bra_pkg::MAP_BYTES) ? bra_pkg::MAP_BYTES : int'(cfg_bytes);
        total = nbytes * 8;
        case (rq.kind)
            bra_pkg::KIND_READ, bra_pkg::KIND_SET, bra_pkg::KIND_CLEAR: begin
                if (rq.idx >= total) begin
                    a.err = 1'b1;
                end else if (rq.kind == bra_pkg::KIND_READ) begin
                    a.bit_value = occ_map[rq.idx[9:3]][rq.idx[2:0]];
                end else if (rq.kind == bra_pkg::KIND_SET) begin
                    occ_map[rq.idx[9:3]][rq.idx[2:0]] = 1'b1;
                end else begin
                    occ_map[rq.idx[9:3]][rq.idx[2:0]] = 1'b0;
                end
            end
            bra_pkg::KIND_SEARCH: begin
                if (rq.len == 0) begin
                    a.err = 1'b1;
                end else if (rq.len <= total) begin
                    run = 0;
                    for (int i = 0; i < total; i++) begin
                        if (occ_map[i / 8][i % 8]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == rq.len) begin
                                a.found = 1'b1;
                                a.start_index = 10'(i + 1 - run);
                                break;
                            end
                        end
                    end
                end
            end
            bra_pkg::KIND_WIPE: begin
                for (int b = 0; b < nbytes; b++) occ_map[b] = '0;
            end
            default: begin
                a.err = 1'b1;
            end
        endcase
        return a;
    endfunction

    function automatic void push_req(logic [2:0] k, int idx, int len);
        t_req rq;
        rq.kind = k;
        rq.idx = idx[9:0];
        rq.len = len[10:0];
        request_q.push_back(rq);
    endfunction

    // mix of single items and set-run / punch-hole / search sequences
    task automatic fill_phase(input int n);
        int total;
        int made;
        int base;
        int cnt;
        int r;
        int idx;
        int len;
        logic [2:0] k;
        total = ((cfg_bytes > bra_pkg::MAP_BYTES) ? bra_pkg::MAP_BYTES
                                                  : int'(cfg_bytes)) * 8;
        made = 0;
        while (made < n) begin
            if (total >= 4 && $urandom_range(0, 99) < 35) begin
                cnt = $urandom_range(2, (total < 16) ? total : 16);
                base = $urandom_range(0, total - cnt);
                for (int j = 0; j < cnt; j++) begin
                    push_req(bra_pkg::KIND_SET, base + j, $urandom_range(0, 2047));
                end
                push_req(bra_pkg::KIND_CLEAR, base + $urandom_range(0, cnt - 1),
                         $urandom_range(0, 2047));
                push_req(bra_pkg::KIND_SEARCH, $urandom_range(0, 1023), $urandom_range(1, 12));
                made += cnt + 2;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20)      k = bra_pkg::KIND_READ;
                else if (r < 45) k = bra_pkg::KIND_SET;
                else if (r < 60) k = bra_pkg::KIND_CLEAR;
                else if (r < 92) k = bra_pkg::KIND_SEARCH;
                else if (r < 95) k = bra_pkg::KIND_WIPE;
                else             k = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
                if (total == 0 || $urandom_range(0, 9) == 0)
                    idx = $urandom_range(0, 1023);
                else if ($urandom_range(0, 1) == 0)
                    idx = $urandom_range(0, ((total < 64) ? total : 64) - 1);
                else
                    idx = $urandom_range(0, total - 1);
                r = $urandom_range(0, 99);
                if (r < 4)       len = 0;
                else if (r < 10) len = $urandom_range(total + 1, 2047);
                else if (r < 70) len = $urandom_range(1, 12);
                else             len = $urandom_range(1, (total > 0) ? total : 1);
                push_req(k, idx, len);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_q.size() != 0 || start || answer_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        cfg_bytes = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                answer_q.push_back(alloc_predict({i_kind, i_bit_index, i_run_length}));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (request_q.size() > 0) begin
                    drv_req = request_q.pop_front();
                    i_kind <= drv_req.kind;
                    i_bit_index <= drv_req.idx;
                    i_run_length <= drv_req.len;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got = {o_bit_value, o_found, o_start_index, o_error};
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected item, expected none got %h", $time, got);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                check_field("bit_value", want.bit_value, got.bit_value);
                check_field("found", want.found, got.found);
                check_field("start_index", want.start_index, got.start_index);
                check_field("error", want.err, got.err);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** bitmap_run_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < bra_pkg::MAP_BYTES; b++) occ_map[b] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_req(bra_pkg::KIND_READ, 0, 0);
        push_req(bra_pkg::KIND_SET, 0, 2047);
        push_req(bra_pkg::KIND_SET, 1023, 0);
        push_req(bra_pkg::KIND_READ, 1023, 1);
        push_req(bra_pkg::KIND_READ, 0, 1);
        push_req(bra_pkg::KIND_CLEAR, 0, 0);
        push_req(bra_pkg::KIND_READ, 0, 0);
        push_req(bra_pkg::KIND_SEARCH, 0, 0);
        push_req(bra_pkg::KIND_SEARCH, 1023, 1);
        push_req(bra_pkg::KIND_SEARCH, 0, 1023);
        push_req(bra_pkg::KIND_SEARCH, 0, 1024);
        push_req(bra_pkg::KIND_CLEAR, 1023, 0);
        push_req(bra_pkg::KIND_SEARCH, 0, 1024);
        push_req(bra_pkg::KIND_SEARCH, 0, 1025);
        push_req(bra_pkg::KIND_SEARCH, 1023, 2047);
        push_req(bra_pkg::KIND_SET, 5, 0);
        push_req(bra_pkg::KIND_SEARCH, 0, 1018);
        push_req(bra_pkg::KIND_SEARCH, 0, 1019);
        push_req(bra_pkg::KIND_READ, 1023, 2047);
        push_req(KIND_RSVD_LO, 1023, 2047);
        push_req(3'(KIND_RSVD_LO + 3'd1), 5, 1);
        push_req(KIND_RSVD_HI, 0, 0);
        push_req(bra_pkg::KIND_WIPE, 0, 0);
        push_req(bra_pkg::KIND_READ, 5, 0);
        wait_idle();

        write_cfg(8'd1);   fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd0);   fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd255); fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd16);  fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd2);   fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd200); fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd128); fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'd64);  fill_phase(PHASE_ITEMS); wait_idle();
        write_cfg(8'($urandom_range(0, 255))); fill_phase(PHASE_ITEMS); wait_idle();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** bitmap_run_allocator: PASSED **");
        end else begin
            $display("** bitmap_run_allocator: FAILED **");
        end
        $finish;
    end

endmodule
